### sv/fuf_pkg.sv
// Shared types, codes and constants of the fixed-unit free-list allocator.
package fuf_pkg;

  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 16;
  localparam int RSIZE_W       = 17;
  localparam int POOL_W        = 9;
  localparam int STATUS_W      = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int DIV_CNT_W     = $clog2(ADDR_W);
  localparam int DEF_MAX_UNITS = 256;

  localparam logic [POOL_W-1:0] COUNT_MAX        = '1;
  localparam logic [SIZE_W-1:0] RST_UNIT_SIZE    = 16'd4;
  localparam logic [POOL_W-1:0] RST_POOL_UNITS   = 9'd256;
  localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = '0;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SELF_LINK = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_IS_HEAD   = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_SIZE    = 2'd0,
    CFG_POOL_UNITS   = 2'd1,
    CFG_BASE_ADDRESS = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_ADDR,
    S_DIVIDE,
    S_RESULT
  } state_t;

  // Pool settings as seen by the sequencer.
  typedef struct packed {
    logic               rebuild;
    logic [RSIZE_W-1:0] rsize;
    logic [POOL_W-1:0]  count;
    logic [ADDR_W-1:0]  base;
  } pool_cfg_t;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [RSIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/fuf_req_if.sv
// Request channel: one allocate or free per beat.
interface fuf_req_if;
  logic                        valid;
  logic                        ready;
  fuf_pkg::action_t            action;
  logic [fuf_pkg::ADDR_W-1:0]  address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

### sv/fuf_rsp_if.sv
// Response channel: one status, address and free count per beat.
interface fuf_rsp_if;
  logic                        valid;
  logic                        ready;
  fuf_pkg::status_t            status;
  logic [fuf_pkg::ADDR_W-1:0]  unit_address;
  logic [fuf_pkg::POOL_W-1:0]  free_units;

  modport source (output valid, status, unit_address, free_units, input ready);
  modport sink   (input valid, status, unit_address, free_units, output ready);
endinterface

### sv/fuf_cfg_if.sv
// Configuration write channel: register index and write data per beat.
interface fuf_cfg_if;
  logic                        valid;
  logic                        ready;
  fuf_pkg::cfg_index_t         index;
  logic [fuf_pkg::ADDR_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/fuf_link_mem.sv
// Link store: one write port and one read port with registered read data.
module fuf_link_mem #(
  parameter int MAX_UNITS = fuf_pkg::DEF_MAX_UNITS,
  parameter int IDX_W     = $clog2(MAX_UNITS)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0] mem [MAX_UNITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/fuf_div.sv
// Serial restoring divider: one quotient bit per cycle.
module fuf_div (
  input  logic                clk,
  input  logic                rst,
  input  fuf_pkg::div_req_t   req,
  output fuf_pkg::div_rsp_t   rsp
);
  import fuf_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RSIZE_W-1:0]   rem;
  logic [ADDR_W-1:0]    quo;
  logic [RSIZE_W-1:0]   divisor;
  logic [RSIZE_W:0]     shifted;
  logic [RSIZE_W:0]     trial;
  logic                 fits;

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_comb begin
    shifted = {rem, quo[ADDR_W-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == DIV_CNT_W'(ADDR_W - 1));
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        rem <= fits ? trial[RSIZE_W-1:0] : shifted[RSIZE_W-1:0];
        quo <= {quo[ADDR_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

### sv/fuf_seq.sv
// Sequencer: link-store sweep, allocate and free steps, response register.
module fuf_seq #(
  parameter int MAX_UNITS = fuf_pkg::DEF_MAX_UNITS,
  parameter int IDX_W     = $clog2(MAX_UNITS)
) (
  input  logic                clk,
  input  logic                rst,
  input  fuf_pkg::pool_cfg_t  pool,
  fuf_req_if.sink             req,
  fuf_rsp_if.source           rsp,
  output fuf_pkg::div_req_t   div_req,
  input  fuf_pkg::div_rsp_t   div_rsp,
  output logic                mem_wr_en,
  output logic [IDX_W-1:0]    mem_wr_addr,
  output logic [IDX_W-1:0]    mem_wr_data,
  output logic                mem_rd_en,
  output logic [IDX_W-1:0]    mem_rd_addr,
  input  logic [IDX_W-1:0]    mem_rd_data
);
  import fuf_pkg::*;

  localparam int PROD_W = IDX_W + RSIZE_W;

  state_t               state, state_next;
  logic [IDX_W-1:0]     head;
  logic [POOL_W-1:0]    free_count;
  logic [IDX_W-1:0]     sweep_cnt;
  logic [PROD_W-1:0]    prod;
  status_t              res_status;
  logic [ADDR_W-1:0]    res_addr;

  logic                 accept;
  logic                 addr_below;
  logic                 sweep_last;
  logic [IDX_W:0]       sweep_succ;
  logic                 self_linked;
  logic                 q_outside;
  logic [IDX_W-1:0]     q_idx;
  logic                 is_head;
  logic                 rsp_free;

  always_comb begin
    accept      = req.valid && req.ready;
    addr_below  = req.address < pool.base;
    sweep_last  = (sweep_cnt == IDX_W'(MAX_UNITS - 1));
    sweep_succ  = {1'b0, sweep_cnt} + 1'b1;
    self_linked = (free_count > POOL_W'(1)) && (mem_rd_data == head);
    q_outside   = div_rsp.quotient >= ADDR_W'(pool.count);
    q_idx       = div_rsp.quotient[IDX_W-1:0];
    is_head     = (free_count != '0) && (q_idx == head);
    rsp_free    = !rsp.valid || rsp.ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req.action == ACT_ALLOC) begin
            state_next = (free_count == '0) ? S_RESULT : S_READ;
          end else begin
            state_next = addr_below ? S_RESULT : S_DIVIDE;
          end
        end
      end
      S_READ:   state_next = S_CHECK;
      S_CHECK:  state_next = self_linked ? S_RESULT : S_ADDR;
      S_ADDR:   state_next = S_RESULT;
      S_DIVIDE: begin
        if (div_rsp.done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default:  state_next = S_SWEEP;
    endcase
    if (pool.rebuild) state_next = S_SWEEP;
  end

  // Control outputs: handshake, link-store ports and divider start.
  always_comb begin
    req.ready        = (state == S_IDLE) && !pool.rebuild;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = sweep_cnt;
    mem_wr_data      = '0;
    mem_rd_en        = 1'b0;
    mem_rd_addr      = head;
    div_req.start    = 1'b0;
    div_req.dividend = req.address - pool.base;
    div_req.divisor  = pool.rsize;
    unique case (state)
      S_SWEEP: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = (32'(sweep_succ) < 32'(pool.count)) ? sweep_succ[IDX_W-1:0] : '0;
      end
      S_IDLE: begin
        mem_rd_en     = accept && (req.action == ACT_ALLOC);
        div_req.start = accept && (req.action == ACT_FREE) && !addr_below;
      end
      S_DIVIDE: begin
        mem_wr_en   = div_rsp.done && !q_outside && !is_head;
        mem_wr_addr = q_idx;
        mem_wr_data = head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      head       <= '0;
      free_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_RESULT) && rsp_free && !pool.rebuild) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (pool.rebuild) begin
        sweep_cnt <= '0;
      end else begin
        unique case (state)
          S_SWEEP: begin
            sweep_cnt <= sweep_cnt + 1'b1;
            if (sweep_last) begin
              head       <= '0;
              free_count <= pool.count;
            end
          end
          S_IDLE: begin
            res_addr <= '0;
            if (req.action == ACT_ALLOC) begin
              res_status <= ST_EMPTY;
            end else begin
              res_status <= ST_OUTSIDE;
            end
          end
          S_CHECK: begin
            if (self_linked) begin
              res_status <= ST_SELF_LINK;
            end else begin
              prod       <= PROD_W'(head) * PROD_W'(pool.rsize);
              head       <= mem_rd_data;
              free_count <= free_count - 1'b1;
            end
          end
          S_ADDR: begin
            res_status <= ST_OK;
            res_addr   <= pool.base + ADDR_W'(prod);
          end
          S_DIVIDE: begin
            if (div_rsp.done) begin
              if (q_outside) begin
                res_status <= ST_OUTSIDE;
              end else if (is_head) begin
                res_status <= ST_IS_HEAD;
              end else begin
                res_status <= ST_OK;
                head       <= q_idx;
                if (free_count != COUNT_MAX) free_count <= free_count + 1'b1;
              end
            end
          end
          S_RESULT: begin
            if (rsp_free) begin
              rsp.status       <= res_status;
              rsp.unit_address <= res_addr;
              rsp.free_units   <= free_count;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### sv/fixed_unit_free_list_allocator.sv
// Top level of the fixed-unit free-list allocator: registers and unit wiring.
//
//   Channel  Dir  Payload                               Beat taken when
//   req      in   action, address                       valid && ready
//   rsp      out  status, unit_address, free_units      valid && ready
//   cfg      in   index, data                           valid && ready (ready always high)
//
// An allocate runs a link-store read, a self-link compare, a multiply and an add; multiply
// and add are skipped when the head is self-linked, and an empty pool goes straight to the response.
// A free runs the 32-step serial divider that turns the address offset into a unit index,
// and skips it when the address lies below the pool.
// After reset and any write to unit_size or pool_units, a sweep over all MAX_UNITS entries rebuilds
// the link store with req.ready low. A stalled response lets one more request run up to it.
module fixed_unit_free_list_allocator #(
  parameter int MAX_UNITS = fuf_pkg::DEF_MAX_UNITS
) (
  input  logic      clk,
  input  logic      rst,
  fuf_req_if.sink   req,
  fuf_rsp_if.source rsp,
  fuf_cfg_if.sink   cfg
);
  import fuf_pkg::*;

  localparam int IDX_W = $clog2(MAX_UNITS);

  logic [SIZE_W-1:0]  unit_size;
  logic [POOL_W-1:0]  pool_units;
  logic [ADDR_W-1:0]  base_address;
  logic               cfg_write;
  logic [RSIZE_W-1:0] size_up;
  pool_cfg_t          pool;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [IDX_W-1:0]   mem_wr_data;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic [IDX_W-1:0]   mem_rd_data;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_size    <= RST_UNIT_SIZE;
      pool_units   <= RST_POOL_UNITS;
      base_address <= RST_BASE_ADDRESS;
    end else if (cfg_write) begin
      case (cfg.index)
        CFG_UNIT_SIZE:    unit_size    <= cfg.data[SIZE_W-1:0];
        CFG_POOL_UNITS:   pool_units   <= cfg.data[POOL_W-1:0];
        CFG_BASE_ADDRESS: base_address <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Unit size rounding is done at 17 bits so the top sizes round to 65536.
  always_comb begin
    size_up = ({1'b0, unit_size} + RSIZE_W'(3)) & ~RSIZE_W'(3);
    if (unit_size <= SIZE_W'(2)) begin
      pool.rsize = RSIZE_W'(2);
    end else if (unit_size <= SIZE_W'(4)) begin
      pool.rsize = RSIZE_W'(4);
    end else begin
      pool.rsize = size_up;
    end
    if (32'(pool_units) > 32'(MAX_UNITS)) begin
      pool.count = POOL_W'(MAX_UNITS);
    end else begin
      pool.count = pool_units;
    end
    pool.base    = base_address;
    pool.rebuild = cfg_write &&
                   (cfg.index == CFG_UNIT_SIZE || cfg.index == CFG_POOL_UNITS);
  end

  fuf_seq #(
    .MAX_UNITS (MAX_UNITS),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .pool        (pool),
    .req         (req),
    .rsp         (rsp),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  fuf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fuf_link_mem #(
    .MAX_UNITS (MAX_UNITS),
    .IDX_W     (IDX_W)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

### bench/testbench.sv
// Self-checking testbench for the fixed-unit free-list allocator.
`timescale 1ns / 100ps

module testbench;
  import fuf_pkg::*;

  localparam int POOL_DEPTH     = DEF_MAX_UNITS;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int HAMMER_PHASE   = 3;
  localparam int HAMMER_ITEMS   = 300;
  localparam int PRESSURE_PHASE = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] unit_address;
    logic [POOL_W-1:0] free_units;
  } outcome_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cfg_index_t        reg_idx;
    action_t           act;
    logic [ADDR_W-1:0] value;
    bit                typed;
    outcome_t          want;
  } row_t;

  localparam int PLAN_ROWS = 35;

  // Rows with typed outcomes follow directly from the reset pool layout and the writes before them.
  row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b1, '{ST_OK, 32'h0, 9'd255}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b1, '{ST_OK, 32'h4, 9'd254}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'hFFFFFFFF, 1'b1, '{ST_OUTSIDE, 32'h0, 9'd254}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h400,      1'b1, '{ST_OUTSIDE, 32'h0, 9'd254}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h3FF,      1'b1, '{ST_OK, 32'h0, 9'd255}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h3FD,      1'b1, '{ST_IS_HEAD, 32'h0, 9'd255}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h5,        1'b1, '{ST_OK, 32'h0, 9'd256}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h0,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b0, '0},
    '{ROW_WRITE, CFG_POOL_UNITS,   ACT_ALLOC, 32'h1,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b1, '{ST_OK, 32'h0, 9'd0}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b1, '{ST_EMPTY, 32'h0, 9'd0}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h3,        1'b1, '{ST_OK, 32'h0, 9'd1}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h0,        1'b1, '{ST_IS_HEAD, 32'h0, 9'd1}},
    '{ROW_WRITE, CFG_UNIT_SIZE,    ACT_ALLOC, 32'hFFFF,     1'b0, '0},
    '{ROW_WRITE, CFG_BASE_ADDRESS, ACT_ALLOC, 32'hFFFFFFFF, 1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'hFFFFFFFE, 1'b1, '{ST_OUTSIDE, 32'h0, 9'd1}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'hFFFFFFFF, 1'b1, '{ST_IS_HEAD, 32'h0, 9'd1}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b1, '{ST_OK, 32'hFFFFFFFF, 9'd0}},
    '{ROW_WRITE, CFG_POOL_UNITS,   ACT_ALLOC, 32'h0,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'hFFFFFFFF, 1'b1, '{ST_EMPTY, 32'h0, 9'd0}},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'hFFFFFFFF, 1'b1, '{ST_OUTSIDE, 32'h0, 9'd0}},
    '{ROW_WRITE, CFG_POOL_UNITS,   ACT_ALLOC, 32'h1FF,      1'b0, '0},
    '{ROW_WRITE, CFG_UNIT_SIZE,    ACT_ALLOC, 32'h1,        1'b0, '0},
    '{ROW_WRITE, CFG_BASE_ADDRESS, ACT_ALLOC, 32'hFFFFFF00, 1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'hFFFFFFFF, 1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b0, '0},
    '{ROW_WRITE, CFG_UNIT_SIZE,    ACT_ALLOC, 32'h3,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'h0,        1'b0, '0},
    '{ROW_WRITE, CFG_UNIT_SIZE,    ACT_ALLOC, 32'h5,        1'b0, '0},
    '{ROW_WRITE, CFG_BASE_ADDRESS, ACT_ALLOC, 32'h0,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_FREE,  32'hF,        1'b0, '0},
    '{ROW_ITEM,  CFG_UNUSED,       ACT_ALLOC, 32'h0,        1'b0, '0}
  };

  logic clk;
  logic rst;

  fuf_req_if req ();
  fuf_rsp_if rsp ();
  fuf_cfg_if cfg ();

  fixed_unit_free_list_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Mirror of the allocator state and its settings.
  logic [7:0]        link_mem [POOL_DEPTH];
  logic [7:0]        head_idx;
  logic [POOL_W-1:0] free_cnt;
  logic [SIZE_W-1:0] size_reg;
  logic [POOL_W-1:0] pool_reg;
  logic [ADDR_W-1:0] base_reg;

  outcome_t          pending_replies [$];
  logic [ADDR_W-1:0] held_units [$];
  int                fault_count;
  int                stall_cycles;
  bit                steady_flow;
  bit                hold_replies;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [RSIZE_W-1:0] unit_bytes();
    logic [RSIZE_W-1:0] wide;
    wide = {1'b0, size_reg};
    if (wide <= 2) return 17'd2;
    if (wide <= 4) return 17'd4;
    return (wide + 17'd3) & ~17'd3;
  endfunction

  function automatic int unsigned pool_count();
    return (pool_reg > POOL_DEPTH) ? POOL_DEPTH : pool_reg;
  endfunction

  function automatic void rebuild_pool();
    int unsigned n;
    n = pool_count();
    for (int i = 0; i < POOL_DEPTH; i++) link_mem[i] = (i + 1 < n) ? 8'(i + 1) : 8'd0;
    head_idx = '0;
    free_cnt = POOL_W'(n);
    held_units.delete();
  endfunction

  function automatic void apply_setting(cfg_index_t idx, logic [ADDR_W-1:0] value);
    case (idx)
      CFG_UNIT_SIZE: begin
        size_reg = value[SIZE_W-1:0];
        rebuild_pool();
      end
      CFG_POOL_UNITS: begin
        pool_reg = value[POOL_W-1:0];
        rebuild_pool();
      end
      CFG_BASE_ADDRESS: base_reg = value;
      default: ;
    endcase
  endfunction

  // Works out the reply to one request and moves the mirrored free list along.
  function automatic outcome_t advance_allocator(action_t act, logic [ADDR_W-1:0] addr);
    outcome_t          res;
    logic [RSIZE_W-1:0] sz;
    int unsigned       n;
    logic [7:0]        h;
    logic [7:0]        nxt;
    logic [ADDR_W-1:0] prod;
    logic [ADDR_W-1:0] quot;
    logic [63:0]       span;
    sz = unit_bytes();
    n = pool_count();
    res.status = ST_OK;
    res.unit_address = '0;
    if (act == ACT_ALLOC) begin
      if (free_cnt == 0) begin
        res.status = ST_EMPTY;
      end else begin
        h = head_idx;
        nxt = link_mem[h];
        // With a single free unit the head link carries no meaning.
        if (free_cnt > 1 && nxt == h) begin
          res.status = ST_SELF_LINK;
        end else begin
          prod = {24'b0, h} * {15'b0, sz};
          res.unit_address = base_reg + prod;
          head_idx = nxt;
          free_cnt = free_cnt - 1'b1;
        end
      end
    end else begin
      span = n * sz;
      if (addr < base_reg || {32'b0, addr} >= {32'b0, base_reg} + span) begin
        res.status = ST_OUTSIDE;
      end else begin
        quot = (addr - base_reg) / sz;
        if (free_cnt > 0 && quot[7:0] == head_idx) begin
          res.status = ST_IS_HEAD;
        end else begin
          link_mem[quot[7:0]] = head_idx;
          head_idx = quot[7:0];
          if (free_cnt < COUNT_MAX) free_cnt = free_cnt + 1'b1;
        end
      end
    end
    res.free_units = free_cnt;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    fault_count++;
  endtask

  task automatic issue(action_t act, logic [ADDR_W-1:0] addr, bit typed, outcome_t want);
    int unsigned gap;
    outcome_t    got;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.action  <= act;
    req.address <= addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    got = advance_allocator(act, addr);
    pending_replies.push_back(typed ? want : got);
    if (act == ACT_ALLOC && got.status == ST_OK) held_units.push_back(got.unit_address);
  endtask

  // Settings change only with no reply outstanding and the rebuild sweep done.
  task automatic write_reg(cfg_index_t idx, logic [ADDR_W-1:0] value);
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0 || !req.ready);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    apply_setting(idx, value);
  endtask

  task automatic pick_settings(bit saturate);
    logic [SIZE_W-1:0] sz;
    logic [POOL_W-1:0] units;
    logic [ADDR_W-1:0] origin;
    case ($urandom_range(0, 9))
      0: sz = SIZE_W'($urandom_range(1, 2));
      1: sz = SIZE_W'($urandom_range(3, 4));
      2: sz = SIZE_W'($urandom_range(65533, 65535));
      3: sz = SIZE_W'($urandom);
      default: sz = SIZE_W'($urandom_range(5, 40));
    endcase
    case ($urandom_range(0, 9))
      0: units = '0;
      1: units = POOL_W'($urandom_range(255, 256));
      2: units = POOL_W'($urandom);
      default: units = POOL_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 3))
      0: origin = '0;
      1: origin = 32'hFFFFFFFF - $urandom_range(0, 4095);
      default: origin = $urandom;
    endcase
    // Saturating the free count needs a full pool that does not wrap.
    if (saturate) begin
      sz = SIZE_W'($urandom_range(1, 64));
      units = 9'd256;
      origin = $urandom_range(0, 1 << 20);
    end
    if (saturate || $urandom_range(0, 3) != 0) write_reg(CFG_UNIT_SIZE, {16'b0, sz});
    if (saturate || $urandom_range(0, 3) != 0) write_reg(CFG_POOL_UNITS, {23'b0, units});
    write_reg(CFG_BASE_ADDRESS, origin);
  endtask

  // Allocates and frees; the frees are mostly of units handed out earlier, with some strays and outsiders.
  task automatic random_item();
    logic [ADDR_W-1:0]  addr;
    logic [RSIZE_W-1:0] sz;
    int unsigned        n;
    int unsigned        roll;
    int unsigned        pick;
    sz = unit_bytes();
    n = pool_count();
    roll = $urandom_range(0, 99);
    addr = $urandom;
    if (roll < 45) begin
      issue(ACT_ALLOC, addr, 1'b0, '0);
    end else if (roll < 80 && held_units.size() > 0) begin
      pick = $urandom_range(0, held_units.size() - 1);
      addr = held_units[pick] + $urandom_range(0, sz - 1);
      held_units.delete(pick);
      issue(ACT_FREE, addr, 1'b0, '0);
    end else if (roll < 92 && n > 0) begin
      addr = base_reg + $urandom_range(0, n * sz - 1);
      issue(ACT_FREE, addr, 1'b0, '0);
    end else begin
      issue(ACT_FREE, addr, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned       batch;
    int unsigned       unit_a;
    int unsigned       unit_b;
    int                random_sent;
    int                phase;
    logic [ADDR_W-1:0] addr;
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.action  <= ACT_ALLOC;
    req.address <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= CFG_UNIT_SIZE;
    cfg.data    <= '0;
    fault_count  = 0;
    steady_flow  = 1'b0;
    hold_replies = 1'b0;
    size_reg = RST_UNIT_SIZE;
    pool_reg = RST_POOL_UNITS;
    base_reg = RST_BASE_ADDRESS;
    rebuild_pool();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) write_reg(plan[r].reg_idx, plan[r].value);
      else issue(plan[r].act, plan[r].value, plan[r].typed, plan[r].want);
    end

    random_sent = 0;
    for (phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
      pick_settings(phase == HAMMER_PHASE);
      steady_flow = (phase == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      if (phase == PRESSURE_PHASE) hold_replies = 1'b1;
      if (phase == HAMMER_PHASE) begin
        // Freeing two units in turn pushes each again and again.
        unit_a = $urandom_range(0, POOL_DEPTH - 1);
        unit_b = (unit_a + $urandom_range(1, POOL_DEPTH - 1)) % POOL_DEPTH;
        for (int k = 0; k < HAMMER_ITEMS; k++) begin
          addr = base_reg + ((k % 2) ? unit_a : unit_b) * unit_bytes();
          issue(ACT_FREE, addr, 1'b0, '0);
        end
        batch = HAMMER_ITEMS;
      end else begin
        batch = $urandom_range(40, 120);
        repeat (batch) random_item();
      end
      random_sent += batch;
    end

    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int unsigned pause;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_replies) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_replies = 1'b0;
      end
      pause = steady_flow ? 0 : $urandom_range(0, 9);
      if (pause > 0) begin
        rsp.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", rsp.unit_address, '0);
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.unit_address !== want.unit_address)
          report_mismatch("unit_address", rsp.unit_address, want.unit_address);
        if (rsp.free_units !== want.free_units)
          report_mismatch("free_units", 32'(rsp.free_units), 32'(want.free_units));
      end
    end
  end

  // Ends the run when no beat has moved on any channel for too long.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

### filelist.f
sv/fuf_pkg.sv
sv/fuf_req_if.sv
sv/fuf_rsp_if.sv
sv/fuf_cfg_if.sv
sv/fuf_link_mem.sv
sv/fuf_div.sv
sv/fuf_seq.sv
sv/fixed_unit_free_list_allocator.sv
bench/testbench.sv
